FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a property in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

FILE: rtl/sp2p_pkg.sv
`timescale 1ns / 1ps

package sp2p_pkg;

  localparam int OFF_W  = 25;
  localparam int BYTE_W = 8;
  localparam int CFG_W  = 13;
  localparam int MODE_W = 2;
  localparam int IDX_W  = 2;
  localparam int NUM_LANES = 4;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAME_MODE   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_PROG  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIELD = 2'd1;

  localparam logic [CFG_W-1:0]  RST_FRAME_WIDTH  = 13'd1920;
  localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT = 13'd1080;
  localparam logic [MODE_W-1:0] RST_FRAME_MODE   = MODE_PROG;

  // One accepted pair, with the offset of its first write and the two
  // strides the lanes add on top of it.
  typedef struct packed {
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic [OFF_W-1:0]  off0;
    logic [OFF_W-1:0]  d_odd;
    logic [OFF_W-1:0]  d_upper;
    logic              field;
    logic              frame_done;
  } item_t;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [BYTE_W-1:0] value;
  } lane_wr_t;

endpackage

FILE: rtl/sp2p_lane.sv
`timescale 1ns / 1ps

module sp2p_lane import sp2p_pkg::*; #(
  parameter int LANE = 0
) (
  input  item_t    item,
  output lane_wr_t wr
);

  // odd lanes carry the second byte (odd luma column or Cr),
  // upper lanes the doubled line in field mode
  localparam bit ODD   = (LANE % 2) == 1;
  localparam bit UPPER = LANE >= 2;

  logic [OFF_W-1:0] add_odd;
  logic [OFF_W-1:0] add_upper;

  assign add_odd   = ODD   ? item.d_odd   : '0;
  assign add_upper = UPPER ? item.d_upper : '0;

  assign wr.offset = item.off0 + add_odd + add_upper;
  assign wr.value  = ODD ? item.second_byte : item.first_byte;

endmodule

FILE: rtl/sp2p_track.sv
`timescale 1ns / 1ps

module sp2p_track import sp2p_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_first,
  input  logic [BYTE_W-1:0] in_second,
  output logic              in_ready,
  input  logic              item_take,
  output logic              item_valid,
  output item_t             item
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = WW - 1;

  logic [CFG_W-1:0]  frame_width;
  logic [CFG_W-1:0]  frame_height;
  logic [MODE_W-1:0] frame_mode;
  logic              settle;

  logic [WW-1:0]    w_sat;
  logic [WW-1:0]    w_eff;
  logic [PW-1:0]    pairs;
  logic [HW-1:0]    h_sat;
  logic [HW-1:0]    rows;
  logic             field;
  logic             active;
  logic [WW+HW-1:0] prod;
  logic [OFF_W:0]   plane;

  logic             chroma;
  logic [PW-1:0]    col;
  logic [HW-1:0]    row;
  logic [OFF_W-1:0] luma_base;
  logic [OFF_W-1:0] chroma_base;

  logic             accept;
  logic             col_end;
  logic             row_end;
  logic [OFF_W-1:0] luma_step;
  logic [OFF_W-1:0] chroma_step;
  logic [OFF_W-1:0] off0;

  assign w_sat = ({1'b0, frame_width} > (CFG_W + 1)'(MAX_WIDTH)) ? WW'(MAX_WIDTH)
               : WW'(frame_width);
  assign w_eff = {w_sat[WW-1:1], 1'b0};
  assign pairs = w_sat[WW-1:1];
  assign h_sat = ({1'b0, frame_height} > (CFG_W + 1)'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
               : HW'(frame_height);
  assign field = frame_mode == MODE_FIELD;
  assign rows  = field ? (h_sat >> 1) : h_sat;
  assign active = (frame_mode == MODE_PROG || field) && pairs != '0 && rows != '0;

  assign prod = w_eff * h_sat;

  // plane size, one extra bit kept so that plane/2 wraps like the offsets
  always_ff @(posedge clk) begin
    plane <= (OFF_W + 1)'(prod);
  end

  assign in_ready = !settle && (!item_valid || item_take);
  assign accept   = in_valid && in_ready && active;

  assign col_end = PW'(col + 1'b1) == pairs;
  assign row_end = HW'(row + 1'b1) == rows;

  assign luma_step   = field ? OFF_W'({w_eff, 1'b0}) : OFF_W'(w_eff);
  assign chroma_step = field ? OFF_W'({pairs, 1'b0}) : OFF_W'(pairs);

  assign off0 = chroma ? plane[OFF_W-1:0] + chroma_base + OFF_W'(col)
              : luma_base + OFF_W'({col, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      frame_mode   <= RST_FRAME_MODE;
      settle       <= 1'b0;
      chroma       <= 1'b0;
      col          <= '0;
      row          <= '0;
      luma_base    <= '0;
      chroma_base  <= '0;
      item_valid   <= 1'b0;
    end else begin
      settle <= 1'b0;
      if (cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT
          || cfg_index == REG_FRAME_MODE)) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default:          frame_mode   <= cfg_data[MODE_W-1:0];
        endcase
        // restart the frame; plane is registered, so settle holds off input while it follows the new geometry
        settle      <= 1'b1;
        chroma      <= 1'b0;
        col         <= '0;
        row         <= '0;
        luma_base   <= '0;
        chroma_base <= '0;
      end else if (accept) begin
        col <= col_end ? '0 : PW'(col + 1'b1);
        if (col_end) begin
          if (row_end) begin
            row         <= '0;
            luma_base   <= '0;
            chroma_base <= '0;
            chroma      <= !chroma;
          end else begin
            row <= HW'(row + 1'b1);
            if (chroma) begin
              chroma_base <= chroma_base + chroma_step;
            end else begin
              luma_base <= luma_base + luma_step;
            end
          end
        end
      end

      if (accept) begin
        item_valid <= 1'b1;
      end else if (item_take) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.first_byte  <= in_first;
      item.second_byte <= in_second;
      item.off0        <= off0;
      item.d_odd       <= chroma ? plane[OFF_W:1] : OFF_W'(1);
      item.d_upper     <= chroma ? OFF_W'(pairs) : OFF_W'(w_eff);
      item.field       <= field;
      item.frame_done  <= chroma && col_end && row_end;
    end
  end

endmodule

FILE: rtl/sp2p_merge.sv
`timescale 1ns / 1ps

module sp2p_merge import sp2p_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  logic     item_field,
  input  logic     item_done,
  input  lane_wr_t lane_wr [NUM_LANES],
  output logic     item_take,
  output logic     out_valid,
  input  logic     out_ready,
  output lane_wr_t out_wr,
  output logic     out_last,
  output logic     out_frame_end
);

  localparam int LW = $clog2(NUM_LANES);

  lane_wr_t       wr_buf [NUM_LANES];
  logic           buf_field;
  logic           buf_done;
  logic [LW-1:0]  idx;
  logic [LW-1:0]  last_idx;
  logic           fin;
  logic           load;

  // progressive uses lanes 0..1, field mode all four
  assign last_idx  = buf_field ? LW'(NUM_LANES - 1) : LW'(1);
  assign out_last  = idx == last_idx;
  assign fin       = out_valid && out_ready && out_last;
  assign item_take = !out_valid || fin;
  assign load      = item_valid && item_take;

  assign out_wr        = wr_buf[idx];
  assign out_frame_end = out_last && buf_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= '0;
    end else if (fin) begin
      out_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      idx <= LW'(idx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      wr_buf    <= lane_wr;
      buf_field <= item_field;
      buf_done  <= item_done;
    end
  end

endmodule

FILE: rtl/semiplanar_to_planar_422_converter.sv
`timescale 1ns / 1ps

// Converts a 4:2:2 semi-planar frame, fed as byte pairs (all luma rows, then
// the interleaved Cb/Cr rows), into byte writes of a planar 4:2:2 layout
// given as offsets from the destination start (Y at 0, Cb at W*H, Cr at
// W*H*3/2). Each pair gives 2 writes in progressive mode and 4 in field
// mode, where every row is written to two destination lines. The single
// write port sets the pace while m_tready stays high, since the four lanes
// build all writes of a pair at once and the next pair is taken while the
// current one drains. An accepted pair is registered in the tracker, then
// in the merge buffer. Pairs in mode none or spare or with empty geometry
// are taken and dropped. After a register write s_tready is low in the
// next cycle, and the frame position restarts at the first luma pair.
module semiplanar_to_planar_422_converter import sp2p_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // first_byte, second_byte
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,   // dest_offset, byte_value, zero pad
  output logic              m_tlast,
  output logic              m_tuser    // frame_end
);

  `include "assert_macros.svh"

  logic     item_valid;
  logic     item_take;
  item_t    item;
  lane_wr_t lane_wr [NUM_LANES];
  lane_wr_t out_wr;
  logic     out_frame_end;

  sp2p_track #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .in_first   (s_tdata[7:0]),
    .in_second  (s_tdata[15:8]),
    .in_ready   (s_tready),
    .item_take  (item_take),
    .item_valid (item_valid),
    .item       (item)
  );

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    sp2p_lane #(.LANE(g)) u_lane (
      .item (item),
      .wr   (lane_wr[g])
    );
  end

  sp2p_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_field    (item.field),
    .item_done     (item.frame_done),
    .lane_wr       (lane_wr),
    .item_take     (item_take),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_wr        (out_wr),
    .out_last      (m_tlast),
    .out_frame_end (out_frame_end)
  );

  assign m_tdata = {7'd0, out_wr.value, out_wr.offset};
  assign m_tuser = out_frame_end;

  `ASSERT_ALWAYS(a_frame_end_last, !(m_tvalid && m_tuser) || m_tlast,
                 "frame end on a word that is not the last of its pair")
  `ASSERT_NEXT(a_cfg_stall,
               cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT
                 || cfg_index == REG_FRAME_MODE),
               !s_tready, "input taken right after a register write")
  `ASSERT_NEXT(a_pair_complete, m_tvalid && m_tready && !m_tlast, m_tvalid,
               "writes of a pair cut short")

endmodule

FILE: verif/planar_write_checker.sv
`timescale 1ns / 1ps

module planar_write_checker import sp2p_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [15:0]      s_tdata,   // first_byte, second_byte
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [39:0]      m_tdata,   // dest_offset, byte_value, zero pad
  input  logic             m_tlast,
  input  logic             m_tuser,   // frame_end
  output int               mismatches,
  output int               writes_due
);

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [BYTE_W-1:0] value;
    logic              last;
    logic              frame_end;
  } byte_write_t;

  byte_write_t       expected_writes[$];
  int                err_count = 0;

  logic [CFG_W-1:0]  width_reg;
  logic [CFG_W-1:0]  height_reg;
  logic [MODE_W-1:0] mode_reg;

  logic              in_chroma;
  int unsigned       row_idx;
  int unsigned       col_idx;
  logic [OFF_W-1:0]  luma_base;
  logic [OFF_W-1:0]  chroma_base;

  function automatic byte_write_t make_write(input int unsigned off,
                                             input logic [BYTE_W-1:0] val);
    byte_write_t wr;
    wr.offset    = OFF_W'(off);
    wr.value     = val;
    wr.last      = 1'b0;
    wr.frame_end = 1'b0;
    return wr;
  endfunction

  task automatic restart_position();
    in_chroma   = 1'b0;
    row_idx     = 0;
    col_idx     = 0;
    luma_base   = '0;
    chroma_base = '0;
  endtask

  task automatic apply_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_FRAME_WIDTH:  width_reg  = val;
      REG_FRAME_HEIGHT: height_reg = val;
      REG_FRAME_MODE:   mode_reg   = val[MODE_W-1:0];
      default:          return;
    endcase
    restart_position();
  endtask

  task automatic plan_writes(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1);
    int unsigned w, h, pairs, rows, plane, o, cb, cr, step;
    logic        field;
    logic        done;
    byte_write_t batch[$];
    if (mode_reg > MODE_FIELD) return;
    field = (mode_reg == MODE_FIELD);
    w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    w = w & ~32'd1;
    h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    pairs = w >> 1;
    rows  = field ? (h >> 1) : h;
    if (pairs == 0 || rows == 0) return;
    plane = w * h;
    done  = 1'b0;
    step  = field ? 2 : 1;

    if (!in_chroma) begin
      o = luma_base + 2 * col_idx;
      batch.push_back(make_write(o, b0));
      batch.push_back(make_write(o + 1, b1));
      if (field) begin
        batch.push_back(make_write(o + w, b0));
        batch.push_back(make_write(o + w + 1, b1));
      end
    end else begin
      cb = plane + chroma_base + col_idx;
      cr = cb + (plane >> 1);
      batch.push_back(make_write(cb, b0));
      batch.push_back(make_write(cr, b1));
      if (field) begin
        batch.push_back(make_write(cb + pairs, b0));
        batch.push_back(make_write(cr + pairs, b1));
      end
    end

    col_idx++;
    if (col_idx >= pairs) begin
      col_idx = 0;
      row_idx++;
      if (!in_chroma) luma_base = OFF_W'(luma_base + w * step);
      else chroma_base = OFF_W'(chroma_base + pairs * step);
      if (row_idx >= rows) begin
        if (!in_chroma) begin
          row_idx     = 0;
          luma_base   = '0;
          chroma_base = '0;
          in_chroma   = 1'b1;
        end else begin
          restart_position();
          done = 1'b1;
        end
      end
    end

    batch[batch.size()-1].last      = 1'b1;
    batch[batch.size()-1].frame_end = done;
    foreach (batch[i]) expected_writes.push_back(batch[i]);
  endtask

  task automatic check_write();
    byte_write_t      want;
    logic [OFF_W-1:0] got_off;
    logic [BYTE_W-1:0] got_val;
    got_off = m_tdata[OFF_W-1:0];
    got_val = m_tdata[OFF_W +: BYTE_W];
    if (expected_writes.size() == 0) begin
      $error("unexpected write: dest_offset %0d byte_value %0d", got_off, got_val);
      err_count++;
      return;
    end
    want = expected_writes.pop_front();
    if (got_off !== want.offset) begin
      $error("dest_offset: expected %0d, actual %0d", want.offset, got_off);
      err_count++;
    end
    if (got_val !== want.value) begin
      $error("byte_value: expected %0d, actual %0d", want.value, got_val);
      err_count++;
    end
    if (m_tlast !== want.last) begin
      $error("last: expected %0d, actual %0d", want.last, m_tlast);
      err_count++;
    end
    if (m_tuser !== want.frame_end) begin
      $error("frame_end: expected %0d, actual %0d", want.frame_end, m_tuser);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      mode_reg   = RST_FRAME_MODE;
      restart_position();
      expected_writes.delete();
    end else begin
      if (cfg_we) apply_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) plan_writes(s_tdata[7:0], s_tdata[15:8]);
      if (m_tvalid && m_tready) check_write();
    end
    mismatches <= err_count;
    writes_due <= expected_writes.size();
  end

endmodule

FILE: verif/semiplanar_to_planar_422_converter_tb.sv
`timescale 1ns / 1ps

module semiplanar_to_planar_422_converter_tb;
  import sp2p_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 4;
  localparam int RANDOM_ITEMS = 250;
  localparam int CALM_START   = 120;
  localparam int CALM_ITEMS   = 60;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b1;
  logic [39:0]       m_tdata;
  logic              m_tlast;
  logic              m_tuser;

  int                mismatches;
  int                writes_due;
  int                cycle_count = 0;
  logic              calm = 1'b0;

  // planned geometry, mirrored so the stimulus can size whole frames
  int unsigned       cur_w = RST_FRAME_WIDTH;
  int unsigned       cur_h = RST_FRAME_HEIGHT;
  int unsigned       cur_mode = RST_FRAME_MODE;

  semiplanar_to_planar_422_converter dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  planar_write_checker chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .mismatches(mismatches), .writes_due(writes_due)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 8);
  end

  // pairs in one whole frame, 0 when the block drops everything
  function automatic int unsigned frame_pairs(input int unsigned w_in,
                                              input int unsigned h_in,
                                              input int unsigned mode);
    int unsigned w, h;
    if (mode > MODE_FIELD) return 0;
    w = (w_in > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w_in;
    w = w & ~32'd1;
    h = (h_in > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h_in;
    if (mode == MODE_FIELD) h = h >> 1;
    return w * h;
  endfunction

  task automatic set_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  cur_w = val & 32'h1FFF;
      REG_FRAME_HEIGHT: cur_h = val & 32'h1FFF;
      default:          cur_mode = val & 32'h3;
    endcase
  endtask

  // returns at the handshake edge with s_tvalid still high
  task automatic send_pair(input logic [7:0] b0, input logic [7:0] b1);
    while (!calm && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b1, b0};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // stop sending, wait for every write, then let dropped words clear
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (writes_due != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h,
                              input int unsigned mode);
    set_reg(REG_FRAME_WIDTH, w);
    set_reg(REG_FRAME_HEIGHT, h);
    set_reg(REG_FRAME_MODE, mode);
  endtask

  initial begin
    int unsigned counted, fp, n, r;
    int unsigned calm_end;
    calm_end = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry, byte extremes
    send_pair(8'h00, 8'hFF);
    send_pair(8'hFF, 8'h00);
    settle();
    // smallest frame, two frames back to back
    set_geometry(2, 1, MODE_PROG);
    send_random(4);
    settle();
    // odd width and odd height in field mode
    set_geometry(5, 3, MODE_FIELD);
    send_pair(8'hFF, 8'hFF);
    send_random(4);
    settle();
    // oversized geometry saturates
    set_geometry(8191, 8191, MODE_PROG);
    send_random(3);
    settle();
    set_geometry(4096, 4096, MODE_FIELD);
    send_random(3);
    settle();
    // modes and geometry that give no writes, then the smallest field frame
    set_reg(REG_FRAME_MODE, MODE_NONE);
    send_random(2);
    settle();
    set_reg(REG_FRAME_MODE, MODE_SPARE);
    send_random(2);
    settle();
    set_geometry(1, 4, MODE_PROG);
    send_random(2);
    settle();
    set_geometry(4, 0, MODE_PROG);
    send_random(2);
    settle();
    set_geometry(4, 1, MODE_FIELD);
    send_random(2);
    settle();
    set_geometry(2, 2, MODE_FIELD);
    send_random(3);
    settle();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      // one stretch of at least CALM_ITEMS pairs with no idling on either side
      if (counted >= CALM_START && calm_end == 0) calm_end = counted + CALM_ITEMS;
      calm <= (counted < calm_end);
      r = $urandom_range(0, 9);
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 19);
        set_reg(REG_FRAME_WIDTH, (r == 0) ? 8191 : (r == 1) ? 4096 : (r == 2) ? 1 :
                $urandom_range(2, 12));
      end
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 19);
        set_reg(REG_FRAME_HEIGHT, (r == 0) ? 8191 : (r == 1) ? 4096 : (r == 2) ? 0 :
                $urandom_range(1, 6));
      end
      r = $urandom_range(0, 9);
      set_reg(REG_FRAME_MODE, (r < 4) ? MODE_PROG : (r < 8) ? MODE_FIELD :
              (r == 8) ? MODE_NONE : MODE_SPARE);
      fp = frame_pairs(cur_w, cur_h, cur_mode);
      if (fp == 0) begin
        send_random(3);
      end else begin
        if (fp <= 48) n = fp * $urandom_range(1, 3) + $urandom_range(0, fp - 1);
        else n = $urandom_range(4, 20);
        send_random(n);
        counted += n;
      end
      settle();
    end

    if (mismatches == 0 && writes_due == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
